// ===== rtl/core/height_grid_cross_smoother_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef HEIGHT_GRID_CROSS_SMOOTHER_ASSERT_SVH
`define HEIGHT_GRID_CROSS_SMOOTHER_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define HGCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hgcs assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define HGCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hgcs assertion failed");

`endif

// ===== rtl/core/hgcs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Height grid smoother package
// Shared constants, the job type and helpers of the smoother.
// ---------------------------------------------------------------------------
package hgcs_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_ROWS    = 4096;
    localparam int HEIGHT_BITS = 16;
    localparam int SUM_BITS    = HEIGHT_BITS + 4;
    localparam int INDEX_BITS  = 20;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int WCFG_BITS   = 9;
    localparam int HCFG_BITS   = 13;
    localparam int QUEUE_DEPTH = 4;

    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [SUM_BITS-1:0]   sum;
        logic [2:0]                   parts;
        logic [INDEX_BITS-1:0]        index;
        logic                         last;
    } job_t;

    function automatic logic signed [SUM_BITS-1:0] sx(input logic signed [HEIGHT_BITS-1:0] a);
        sx = {{(SUM_BITS-HEIGHT_BITS){a[HEIGHT_BITS-1]}}, a};
    endfunction

endpackage

// ===== rtl/core/hgcs_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Job queue
// Small FIFO that decouples the classifying front from the divider back.
// ---------------------------------------------------------------------------
module hgcs_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hgcs_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output hgcs_pkg::job_t pop_data,
    output logic          empty
);
    import hgcs_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    job_t                slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS:0]   count_reg;

    assign full     = (count_reg == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PTR_BITS+1)'(push && !full) - (PTR_BITS+1)'(pop && !empty);
        end
    end

endmodule

// ===== rtl/core/hgcs_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Smoother front
// Accepts heights, tracks the grid position, reads the row store and forms
// the neighbour sums of the vertices that each height completes.
// ---------------------------------------------------------------------------
module hgcs_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [hgcs_pkg::HCFG_BITS-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [hgcs_pkg::HEIGHT_BITS-1:0] height,
    output logic                                push,
    output hgcs_pkg::job_t                      push_data,
    input  logic                                q_full
);
    import hgcs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic [2:0]                     rcnt_reg;
    logic [WCFG_BITS-1:0]           cfg_w_reg;
    logic [HCFG_BITS-1:0]           cfg_h_reg;
    logic [COL_BITS-1:0]            col_reg, x_reg;
    logic [ROW_BITS-1:0]            row_reg, y_reg;
    logic signed [HEIGHT_BITS-1:0]  v_reg, left1_reg, left2_reg;
    logic signed [HEIGHT_BITS-1:0]  up_l_reg, up_c_reg, up_r_reg, up2_reg;
    logic signed [HEIGHT_BITS-1:0]  mem [2*MAX_WIDTH];
    logic signed [HEIGHT_BITS-1:0]  rd_data_reg;
    logic [COL_BITS:0]              rd_addr;
    logic [INDEX_BITS-1:0]          ybase_reg;
    job_t                           job_reg [3];
    job_t                           job_next [3];
    logic [2:0]                     jv_reg, jv_next;

    logic [WCFG_BITS-1:0]           w_eff;
    logic [HCFG_BITS-1:0]           h_eff;
    logic                           restart, accept;
    logic [COL_BITS-1:0]            x_acc;
    logic [ROW_BITS-1:0]            y_acc;
    logic                           last_row, last_col;
    logic [1:0]                     sel;
    logic [2:0]                     jv_left;

    always_comb
    begin
        if (cfg_w_reg == '0)
            w_eff = WCFG_BITS'(1);
        else if (cfg_w_reg > WCFG_BITS'(MAX_WIDTH))
            w_eff = WCFG_BITS'(MAX_WIDTH);
        else
            w_eff = cfg_w_reg;
        if (cfg_h_reg == '0)
            h_eff = HCFG_BITS'(1);
        else if (cfg_h_reg > HCFG_BITS'(MAX_ROWS))
            h_eff = HCFG_BITS'(MAX_ROWS);
        else
            h_eff = cfg_h_reg;
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign restart  = (WCFG_BITS'(col_reg) >= w_eff) || (HCFG_BITS'(row_reg) >= h_eff);
    assign x_acc    = restart ? '0 : col_reg;
    assign y_acc    = restart ? '0 : row_reg;
    assign last_row = (HCFG_BITS'(y_reg) + HCFG_BITS'(1) == h_eff);
    assign last_col = (WCFG_BITS'(x_reg) + WCFG_BITS'(1) == w_eff);

    // Reads go to the previous row's bank at x-1, x, x+1, then the current
    // bank at x, which still holds the row two above.
    always_comb
    begin
        case (rcnt_reg)
            3'd0:    rd_addr = {~y_reg[0], x_reg - 1'b1};
            3'd1:    rd_addr = {~y_reg[0], x_reg};
            3'd2:    rd_addr = {~y_reg[0], x_reg + 1'b1};
            default: rd_addr = {y_reg[0], x_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CALC)
        begin
            mem[{y_reg[0], x_reg}] <= v_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        job_next[0].sum   = (sx(up_c_reg) <<< 1) + sx(v_reg)
                          + ((x_reg != '0) ? sx(up_l_reg) : '0)
                          + (!last_col ? sx(up_r_reg) : '0)
                          + ((y_reg > ROW_BITS'(1)) ? sx(up2_reg) : '0);
        job_next[0].parts = 3'd3 + 3'(x_reg != '0) + 3'(!last_col) + 3'(y_reg > ROW_BITS'(1));
        job_next[0].index = INDEX_BITS'(ybase_reg - INDEX_BITS'(w_eff) + INDEX_BITS'(x_reg));
        job_next[1].sum   = (sx(left1_reg) <<< 1) + sx(v_reg)
                          + ((x_reg > COL_BITS'(1)) ? sx(left2_reg) : '0)
                          + ((y_reg != '0) ? sx(up_l_reg) : '0);
        job_next[1].parts = 3'd3 + 3'(x_reg > COL_BITS'(1)) + 3'(y_reg != '0);
        job_next[1].index = INDEX_BITS'(ybase_reg + INDEX_BITS'(x_reg) - INDEX_BITS'(1));
        job_next[2].sum   = (sx(v_reg) <<< 1)
                          + ((x_reg != '0) ? sx(left1_reg) : '0)
                          + ((y_reg != '0) ? sx(up_c_reg) : '0);
        job_next[2].parts = 3'd2 + 3'(x_reg != '0) + 3'(y_reg != '0);
        job_next[2].index = INDEX_BITS'(ybase_reg + INDEX_BITS'(x_reg));
        jv_next[0] = (y_reg != '0);
        jv_next[1] = last_row && (x_reg != '0);
        jv_next[2] = last_row && last_col;
        job_next[2].last = jv_next[2];
        job_next[1].last = jv_next[1] && !jv_next[2];
        job_next[0].last = jv_next[0] && !jv_next[1] && !jv_next[2];
    end

    always_comb
    begin
        if (jv_reg[0])
            sel = 2'd0;
        else if (jv_reg[1])
            sel = 2'd1;
        else
            sel = 2'd2;
        jv_left        = jv_reg;
        jv_left[sel]   = 1'b0;
        push           = (state_reg == ST_PUSH) && !q_full;
        push_data      = job_reg[sel];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                if (rcnt_reg == 3'd4)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = (jv_next != '0) ? ST_PUSH : ST_IDLE;
            end
            ST_PUSH:
            begin
                if (push && (jv_left == '0))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg <= height;
        end
        if (state_reg == ST_READ)
        begin
            ybase_reg <= INDEX_BITS'(y_reg * w_eff);
            case (rcnt_reg)
                3'd1:    up_l_reg <= rd_data_reg;
                3'd2:    up_c_reg <= rd_data_reg;
                3'd3:    up_r_reg <= rd_data_reg;
                3'd4:    up2_reg  <= rd_data_reg;
                default: ;
            endcase
        end
        if (state_reg == ST_CALC)
        begin
            job_reg[0] <= job_next[0];
            job_reg[1] <= job_next[1];
            job_reg[2] <= job_next[2];
            left2_reg  <= left1_reg;
            left1_reg  <= v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rcnt_reg  <= '0;
            cfg_w_reg <= WCFG_BITS'(256);
            cfg_h_reg <= HCFG_BITS'(256);
            col_reg   <= '0;
            row_reg   <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            jv_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRID_WIDTH:  cfg_w_reg <= cfg_data[WCFG_BITS-1:0];
                    CFG_GRID_HEIGHT: cfg_h_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                x_reg    <= x_acc;
                y_reg    <= y_acc;
                rcnt_reg <= '0;
                if (WCFG_BITS'(x_acc) + WCFG_BITS'(1) >= w_eff)
                begin
                    col_reg <= '0;
                    if (HCFG_BITS'(y_acc) + HCFG_BITS'(1) >= h_eff)
                        row_reg <= '0;
                    else
                        row_reg <= y_acc + 1'b1;
                end
                else
                begin
                    col_reg <= x_acc + 1'b1;
                    row_reg <= y_acc;
                end
            end
            else if (state_reg == ST_READ)
            begin
                rcnt_reg <= rcnt_reg + 1'b1;
            end
            if (state_reg == ST_CALC)
                jv_reg <= jv_next;
            else if (push)
                jv_reg <= jv_left;
        end
    end

endmodule

// ===== rtl/core/hgcs_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Smoother back
// Divides each queued sum by its part count with rounding to nearest, ties
// away from zero, and presents the result on the output channel.
// ---------------------------------------------------------------------------
module hgcs_back
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    q_empty,
    input  hgcs_pkg::job_t                          q_data,
    output logic                                    pop,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [hgcs_pkg::HEIGHT_BITS-1:0] smoothed_height,
    output logic [hgcs_pkg::INDEX_BITS-1:0]         vertex_index,
    output logic                                    last_of_run
);
    import hgcs_pkg::*;

    localparam int RECIP_BITS  = 21;
    localparam int RECIP_SHIFT = 21;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

    // Reciprocals ceil(2^21 / parts). The rounding error stays below one part
    // in a quotient for every sum magnitude that six heights can reach.
    localparam logic [RECIP_BITS-1:0] RECIP_2 = 21'd1048576;
    localparam logic [RECIP_BITS-1:0] RECIP_3 = 21'd699051;
    localparam logic [RECIP_BITS-1:0] RECIP_4 = 21'd524288;
    localparam logic [RECIP_BITS-1:0] RECIP_5 = 21'd419431;
    localparam logic [RECIP_BITS-1:0] RECIP_6 = 21'd349526;

    localparam logic BK_IDLE = 1'b0;
    localparam logic BK_MUL  = 1'b1;

    logic                          state_reg;
    logic [SUM_BITS-1:0]           num_reg;
    logic [RECIP_BITS-1:0]         recip_reg;
    logic                          neg_reg;
    logic [INDEX_BITS-1:0]         index_reg;
    logic                          last_reg;
    logic                          valid_reg;
    logic signed [HEIGHT_BITS-1:0] result_reg;

    logic [SUM_BITS-1:0]           mag;
    logic [RECIP_BITS-1:0]         recip;
    logic [PROD_BITS-1:0]          product;
    logic [HEIGHT_BITS:0]          quot;

    assign pop             = (state_reg == BK_IDLE) && !q_empty && !valid_reg;
    assign out_valid       = valid_reg;
    assign smoothed_height = result_reg;
    assign vertex_index    = index_reg;
    assign last_of_run     = last_reg;

    assign mag     = q_data.sum[SUM_BITS-1] ? SUM_BITS'(-q_data.sum) : q_data.sum;
    assign product = num_reg * recip_reg;
    assign quot    = product[RECIP_SHIFT +: HEIGHT_BITS+1];

    always_comb
    begin
        case (q_data.parts)
            3'd2:    recip = RECIP_2;
            3'd3:    recip = RECIP_3;
            3'd4:    recip = RECIP_4;
            3'd5:    recip = RECIP_5;
            default: recip = RECIP_6;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            // (2*|sum| + parts) / (2*parts) equals (|sum| + parts/2) / parts.
            num_reg   <= mag + SUM_BITS'(q_data.parts[2:1]);
            recip_reg <= recip;
            neg_reg   <= q_data.sum[SUM_BITS-1];
            index_reg <= q_data.index;
            last_reg  <= q_data.last;
        end
        else if (state_reg == BK_MUL)
        begin
            result_reg <= neg_reg ? HEIGHT_BITS'(-quot) : quot[HEIGHT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                BK_IDLE:
                begin
                    if (pop)
                        state_reg <= BK_MUL;
                end
                BK_MUL:
                begin
                    state_reg <= BK_IDLE;
                    valid_reg <= 1'b1;
                end
                default:
                begin
                    state_reg <= BK_IDLE;
                end
            endcase
            if (valid_reg && !out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/height_grid_cross_smoother.sv =====
`timescale 1ns / 1ps
// A height passes the front's accept, five row store reads and sum step,
// then up to three queue pushes; a result passes the back end's operand
// load and reciprocal multiply. The front takes no new height until its
// pushes are done; the back end takes no job until its result is taken.
// Reset: counters clear to zero, grid_width and grid_height to 256; the row
// store is not cleared.
// ---------------------------------------------------------------------------
// Height grid cross smoother
// Five point weighted smoothing of a raster ordered height grid.
// ---------------------------------------------------------------------------
module height_grid_cross_smoother
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic                                    cfg_index,
    input  logic [hgcs_pkg::HCFG_BITS-1:0]          cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [hgcs_pkg::HEIGHT_BITS-1:0] height,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [hgcs_pkg::HEIGHT_BITS-1:0] smoothed_height,
    output logic [hgcs_pkg::INDEX_BITS-1:0]         vertex_index,
    output logic                                    last_of_run
);
    import hgcs_pkg::*;

    logic push, q_full, pop, q_empty;
    job_t push_data, q_data;

    hgcs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .height    (height),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    hgcs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    hgcs_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_data          (q_data),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .smoothed_height (smoothed_height),
        .vertex_index    (vertex_index),
        .last_of_run     (last_of_run)
    );

endmodule

// ===== rtl/core/hgcs_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Smoother port checker
// Watches the top level ports for handshake and sequencing slips.
// ---------------------------------------------------------------------------
`include "height_grid_cross_smoother_assert.svh"

module hgcs_checker
(
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    cfg_we,
    input logic                                    cfg_index,
    input logic [hgcs_pkg::HCFG_BITS-1:0]          cfg_data,
    input logic                                    in_valid,
    input logic                                    in_stall,
    input logic signed [hgcs_pkg::HEIGHT_BITS-1:0] height,
    input logic                                    out_valid,
    input logic                                    out_stall,
    input logic signed [hgcs_pkg::HEIGHT_BITS-1:0] smoothed_height,
    input logic [hgcs_pkg::INDEX_BITS-1:0]         vertex_index,
    input logic                                    last_of_run
);
    // A stalled result stays presented.
    `HGCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `HGCS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(vertex_index) && $stable(smoothed_height))
    // The front works one transaction at a time, so it is busy right after one.
    `HGCS_ASSERT_NEXT(a_in_busy, clk, rst_n, in_valid && !in_stall, in_stall)
    // The back end loads a new job only once its result register is empty,
    // so results never come back to back.
    `HGCS_ASSERT_NEXT(a_out_gap, clk, rst_n, out_valid && !out_stall, !out_valid)

endmodule

bind height_grid_cross_smoother hgcs_checker u_hgcs_checker (.*);
